@@ hw/rtl/exen_pkg.sv @@
`timescale 1ns / 1ps

package exen_pkg;

    localparam int MASK_W   = 64;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int KIND_W   = 3;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 5;
    localparam int N_SECTIONS = 5;

    localparam logic [COUNT_W-1:0] MAX_ORBITALS  = COUNT_W'(64);
    localparam logic [COUNT_W-1:0] COUNT_RESET   = COUNT_W'(64);
    localparam logic [IDX_W:0]     NO_BIT        = (IDX_W+1)'(MASK_W);

    // Positions of the four derived masks in the scan record
    localparam int MASK_OA = 0;
    localparam int MASK_VA = 1;
    localparam int MASK_OB = 2;
    localparam int MASK_VB = 3;

    typedef enum logic [1:0] {
        REG_ALPHA = 2'd0,
        REG_BETA  = 2'd1,
        REG_COUNT = 2'd2
    } reg_index_t;

    typedef enum logic [KIND_W-1:0] {
        SEC_A_SINGLE = 3'd0,
        SEC_A_DOUBLE = 3'd1,
        SEC_B_SINGLE = 3'd2,
        SEC_B_DOUBLE = 3'd3,
        SEC_MIXED    = 3'd4,
        SEC_DONE     = 3'd5
    } section_t;

    typedef struct packed {
        section_t         sec;
        logic [IDX_W-1:0] h1;
        logic [IDX_W-1:0] h2;
        logic [IDX_W-1:0] p1;
        logic [IDX_W-1:0] p2;
    } cursor_t;

    typedef struct packed {
        logic             any;
        logic             two;
        logic [IDX_W-1:0] lo1;
        logic [IDX_W-1:0] lo2;
        logic [IDX_W-1:0] hi1;
        logic [IDX_W-1:0] hi2;
    } mask_stat_t;

    typedef struct packed {
        logic [MASK_W-1:0]   raw_alpha;
        logic [MASK_W-1:0]   raw_beta;
        logic [MASK_W-1:0]   oa;
        logic [MASK_W-1:0]   va;
        logic [MASK_W-1:0]   ob;
        logic [MASK_W-1:0]   vb;
        mask_stat_t [3:0]    stat;
    } scan_info_t;

    typedef struct packed {
        logic [MASK_W-1:0] alpha;
        logic [MASK_W-1:0] beta;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              exhausted;
    } result_t;

    // Index of the lowest set bit, NO_BIT when the mask is empty
    function automatic logic [IDX_W:0] lowest_bit(input logic [MASK_W-1:0] m);
        logic [MASK_W-1:0] iso;
        logic [IDX_W-1:0]  idx;
        iso = m & (~m + MASK_W'(1));
        idx = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (iso[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
        return (m == '0) ? NO_BIT : {1'b0, idx};
    endfunction

    // Index of the highest set bit, zero when the mask is empty
    function automatic logic [IDX_W-1:0] highest_bit(input logic [MASK_W-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (m[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // First set bit at or above from; NO_BIT when none
    function automatic logic [IDX_W:0] next_set(input logic [MASK_W-1:0] m,
                                                input logic [IDX_W:0]    from);
        logic [MASK_W-1:0] sel;
        sel = from[IDX_W] ? '0 : (m & ({MASK_W{1'b1}} << from[IDX_W-1:0]));
        return lowest_bit(sel);
    endfunction

    function automatic mask_stat_t mask_stat(input logic [MASK_W-1:0] m);
        logic [MASK_W-1:0] rest_lo;
        logic [MASK_W-1:0] rest_hi;
        logic [IDX_W:0]    l1;
        logic [IDX_W:0]    l2;
        mask_stat_t        st;
        l1      = lowest_bit(m);
        rest_lo = m & (m - MASK_W'(1));
        l2      = lowest_bit(rest_lo);
        st.any  = |m;
        st.two  = |rest_lo;
        st.lo1  = l1[IDX_W-1:0];
        st.lo2  = l2[IDX_W-1:0];
        st.hi1  = highest_bit(m);
        rest_hi = m & ~(MASK_W'(1) << st.hi1);
        st.hi2  = highest_bit(rest_hi);
        return st;
    endfunction

    function automatic logic [MASK_W-1:0] one_hot(input logic [IDX_W-1:0] x);
        return MASK_W'(1) << x;
    endfunction

endpackage

@@ hw/rtl/exen_apb_regs.sv @@
`timescale 1ns / 1ps

module exen_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [exen_pkg::ADDR_W-1:0]      paddr,
    input  logic [exen_pkg::DATA_W-1:0]      pwdata,
    output logic [exen_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    output logic [exen_pkg::MASK_W-1:0]      alpha_occupation,
    output logic [exen_pkg::MASK_W-1:0]      beta_occupation,
    output logic [exen_pkg::COUNT_W-1:0]     orbital_count
);
    import exen_pkg::*;

    logic [MASK_W-1:0]  alpha_reg;
    logic [MASK_W-1:0]  alpha_next;
    logic [MASK_W-1:0]  beta_reg;
    logic [MASK_W-1:0]  beta_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               wr_en;
    reg_index_t         index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = reg_index_t'(paddr[ADDR_W-1:3]);

    always_comb
    begin
        alpha_next = alpha_reg;
        beta_next  = beta_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_ALPHA: alpha_next = pwdata[MASK_W-1:0];
                REG_BETA:  beta_next  = pwdata[MASK_W-1:0];
                REG_COUNT: count_next = pwdata[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_ALPHA: prdata = DATA_W'(alpha_reg);
            REG_BETA:  prdata = DATA_W'(beta_reg);
            REG_COUNT: prdata = DATA_W'(count_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            beta_reg  <= '0;
            count_reg <= COUNT_RESET;
        end
        else
        begin
            alpha_reg <= alpha_next;
            beta_reg  <= beta_next;
            count_reg <= count_next;
        end
    end

    assign alpha_occupation = alpha_reg;
    assign beta_occupation  = beta_reg;
    assign orbital_count    = count_reg;

endmodule

@@ hw/rtl/exen_mask_scan.sv @@
`timescale 1ns / 1ps

module exen_mask_scan (
    input  logic [exen_pkg::MASK_W-1:0]  alpha_occupation,
    input  logic [exen_pkg::MASK_W-1:0]  beta_occupation,
    input  logic [exen_pkg::COUNT_W-1:0] orbital_count,
    output exen_pkg::scan_info_t         info
);
    import exen_pkg::*;

    logic [COUNT_W-1:0] n_eff;
    logic [MASK_W-1:0]  valid_mask;

    // Saturate the orbital count, then keep only the orbitals below it
    assign n_eff = (orbital_count > MAX_ORBITALS) ? MAX_ORBITALS : orbital_count;

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            valid_mask[i] = (COUNT_W'(i) < n_eff);
        end
    end

    always_comb
    begin
        info.raw_alpha     = alpha_occupation;
        info.raw_beta      = beta_occupation;
        info.oa            = alpha_occupation & valid_mask;
        info.va            = ~alpha_occupation & valid_mask;
        info.ob            = beta_occupation & valid_mask;
        info.vb            = ~beta_occupation & valid_mask;
        info.stat[MASK_OA] = mask_stat(info.oa);
        info.stat[MASK_VA] = mask_stat(info.va);
        info.stat[MASK_OB] = mask_stat(info.ob);
        info.stat[MASK_VB] = mask_stat(info.vb);
    end

endmodule

@@ hw/rtl/exen_step.sv @@
`timescale 1ns / 1ps

module exen_step (
    input  logic                  restart,
    input  exen_pkg::cursor_t     cur,
    input  exen_pkg::scan_info_t  info,
    output exen_pkg::cursor_t     nxt,
    output exen_pkg::result_t     res
);
    import exen_pkg::*;

    mask_stat_t            st_oa;
    mask_stat_t            st_va;
    mask_stat_t            st_ob;
    mask_stat_t            st_vb;
    logic [N_SECTIONS-1:0] sec_exists;

    logic [IDX_W-1:0]  d0, d1, d2, d3;
    logic [MASK_W-1:0] m0, m1, m2, m3;
    logic              ch1, ch3;

    logic [IDX_W:0]    e3, e2, f3, g1, z2, z3, q0, q1;
    logic [IDX_W-1:0]  n0, n1, n2, n3;
    logic              adv_ok;
    cursor_t           adv;

    logic [KIND_W-1:0] seek_start;
    logic              seek_hit;
    section_t          seek_sec;
    cursor_t           seek;

    logic              found;
    logic              in_last;
    logic              later;

    // No successor for a single: particle at the top and hole cannot be bumped
    function automatic logic single_done(input mask_stat_t occ, input mask_stat_t vir,
                                         input logic [IDX_W-1:0] h,
                                         input logic [IDX_W-1:0] p);
        return (!vir.any || p >= vir.hi1) && (!occ.any || h >= occ.hi1 || !vir.any);
    endfunction

    // No successor for a same-spin double, digit by digit from the fastest
    function automatic logic double_done(input mask_stat_t occ, input mask_stat_t vir,
                                         input logic [IDX_W-1:0] h1,
                                         input logic [IDX_W-1:0] h2,
                                         input logic [IDX_W-1:0] p1,
                                         input logic [IDX_W-1:0] p2);
        return (!vir.any || p2 >= vir.hi1) &&
               (!vir.two || p1 >= vir.hi2) &&
               (!occ.any || h2 >= occ.hi1 || !vir.two) &&
               (!occ.two || h1 >= occ.hi2 || !vir.two);
    endfunction

    assign st_oa = info.stat[MASK_OA];
    assign st_va = info.stat[MASK_VA];
    assign st_ob = info.stat[MASK_OB];
    assign st_vb = info.stat[MASK_VB];

    always_comb
    begin
        sec_exists[SEC_A_SINGLE] = st_oa.any && st_va.any;
        sec_exists[SEC_A_DOUBLE] = st_oa.two && st_va.two;
        sec_exists[SEC_B_SINGLE] = st_ob.any && st_vb.any;
        sec_exists[SEC_B_DOUBLE] = st_ob.two && st_vb.two;
        sec_exists[SEC_MIXED]    = st_oa.any && st_va.any && st_ob.any && st_vb.any;
    end

    // Lay the cursor out as four digits; singles use the two lower-order digits
    always_comb
    begin
        d0 = '0; d1 = '0; d2 = '0; d3 = '0;
        m0 = '0; m1 = '0; m2 = '0; m3 = '0;
        ch1 = 1'b0;
        ch3 = 1'b0;
        unique case (cur.sec)
            SEC_A_SINGLE:
            begin
                d2 = cur.h1; d3 = cur.p1;
                m2 = info.oa; m3 = info.va;
            end
            SEC_B_SINGLE:
            begin
                d2 = cur.h1; d3 = cur.p1;
                m2 = info.ob; m3 = info.vb;
            end
            SEC_A_DOUBLE:
            begin
                d0 = cur.h1; d1 = cur.h2; d2 = cur.p1; d3 = cur.p2;
                m0 = info.oa; m1 = info.oa; m2 = info.va; m3 = info.va;
                ch1 = 1'b1; ch3 = 1'b1;
            end
            SEC_B_DOUBLE:
            begin
                d0 = cur.h1; d1 = cur.h2; d2 = cur.p1; d3 = cur.p2;
                m0 = info.ob; m1 = info.ob; m2 = info.vb; m3 = info.vb;
                ch1 = 1'b1; ch3 = 1'b1;
            end
            SEC_MIXED:
            begin
                d0 = cur.h1; d1 = cur.p1; d2 = cur.h2; d3 = cur.p2;
                m0 = info.oa; m1 = info.va; m2 = info.ob; m3 = info.vb;
            end
            default: ;
        endcase
    end

    // Successor candidates: bump one digit, refill the lower-order ones minimally
    always_comb
    begin
        e3 = next_set(m3, {1'b0, d3} + (IDX_W+1)'(1));
        e2 = next_set(m2, {1'b0, d2} + (IDX_W+1)'(1));
        f3 = next_set(m3, ch3 ? e2 + (IDX_W+1)'(1) : '0);
        g1 = next_set(m1, {1'b0, d1} + (IDX_W+1)'(1));
        z2 = next_set(m2, '0);
        z3 = next_set(m3, ch3 ? z2 + (IDX_W+1)'(1) : '0);
        q0 = next_set(m0, {1'b0, d0} + (IDX_W+1)'(1));
        q1 = next_set(m1, ch1 ? q0 + (IDX_W+1)'(1) : '0);
    end

    always_comb
    begin
        adv_ok = 1'b1;
        n0 = d0; n1 = d1; n2 = d2; n3 = d3;
        priority if (!e3[IDX_W])
        begin
            n3 = e3[IDX_W-1:0];
        end
        else if (!e2[IDX_W] && !f3[IDX_W])
        begin
            n2 = e2[IDX_W-1:0];
            n3 = f3[IDX_W-1:0];
        end
        else if (!g1[IDX_W] && !z2[IDX_W] && !z3[IDX_W])
        begin
            n1 = g1[IDX_W-1:0];
            n2 = z2[IDX_W-1:0];
            n3 = z3[IDX_W-1:0];
        end
        else if (!q0[IDX_W] && !q1[IDX_W] && !z2[IDX_W] && !z3[IDX_W])
        begin
            n0 = q0[IDX_W-1:0];
            n1 = q1[IDX_W-1:0];
            n2 = z2[IDX_W-1:0];
            n3 = z3[IDX_W-1:0];
        end
        else
        begin
            adv_ok = 1'b0;
        end
    end

    always_comb
    begin
        adv.sec = cur.sec;
        adv.h1  = '0;
        adv.h2  = '0;
        adv.p1  = '0;
        adv.p2  = '0;
        unique case (cur.sec)
            SEC_A_SINGLE, SEC_B_SINGLE:
            begin
                adv.h1 = n2; adv.p1 = n3;
            end
            SEC_A_DOUBLE, SEC_B_DOUBLE:
            begin
                adv.h1 = n0; adv.h2 = n1; adv.p1 = n2; adv.p2 = n3;
            end
            SEC_MIXED:
            begin
                adv.h1 = n0; adv.p1 = n1; adv.h2 = n2; adv.p2 = n3;
            end
            default: ;
        endcase
    end

    // First non-empty section from the start point on
    assign seek_start = restart ? '0 : KIND_W'(cur.sec) + KIND_W'(1);

    always_comb
    begin
        seek_hit = 1'b0;
        seek_sec = SEC_DONE;
        for (int s = 0; s < N_SECTIONS; s++)
        begin
            if (!seek_hit && (KIND_W'(s) >= seek_start) && sec_exists[s])
            begin
                seek_hit = 1'b1;
                seek_sec = section_t'(KIND_W'(s));
            end
        end
    end

    always_comb
    begin
        seek.sec = seek_sec;
        seek.h1  = '0;
        seek.h2  = '0;
        seek.p1  = '0;
        seek.p2  = '0;
        unique case (seek_sec)
            SEC_A_SINGLE:
            begin
                seek.h1 = st_oa.lo1; seek.p1 = st_va.lo1;
            end
            SEC_A_DOUBLE:
            begin
                seek.h1 = st_oa.lo1; seek.h2 = st_oa.lo2;
                seek.p1 = st_va.lo1; seek.p2 = st_va.lo2;
            end
            SEC_B_SINGLE:
            begin
                seek.h1 = st_ob.lo1; seek.p1 = st_vb.lo1;
            end
            SEC_B_DOUBLE:
            begin
                seek.h1 = st_ob.lo1; seek.h2 = st_ob.lo2;
                seek.p1 = st_vb.lo1; seek.p2 = st_vb.lo2;
            end
            SEC_MIXED:
            begin
                seek.h1 = st_oa.lo1; seek.p1 = st_va.lo1;
                seek.h2 = st_ob.lo1; seek.p2 = st_vb.lo1;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        priority if (restart)
        begin
            nxt = seek;
        end
        else if (cur.sec == SEC_A_SINGLE || cur.sec == SEC_A_DOUBLE ||
                 cur.sec == SEC_B_SINGLE || cur.sec == SEC_B_DOUBLE ||
                 cur.sec == SEC_MIXED)
        begin
            nxt = adv_ok ? adv : seek;
        end
        else
        begin
            // Already exhausted: hold the indices, park the section
            nxt     = cur;
            nxt.sec = SEC_DONE;
        end
    end

    assign found = (nxt.sec != SEC_DONE);

    // Last in section: no digit can be bumped with the lower ones refilled.
    // Held digits may come from older masks, so compare against the top bits.
    always_comb
    begin
        unique case (nxt.sec)
            SEC_A_SINGLE: in_last = single_done(st_oa, st_va, nxt.h1, nxt.p1);
            SEC_A_DOUBLE: in_last = double_done(st_oa, st_va, nxt.h1, nxt.h2,
                                                nxt.p1, nxt.p2);
            SEC_B_SINGLE: in_last = single_done(st_ob, st_vb, nxt.h1, nxt.p1);
            SEC_B_DOUBLE: in_last = double_done(st_ob, st_vb, nxt.h1, nxt.h2,
                                                nxt.p1, nxt.p2);
            SEC_MIXED:    in_last = (!st_vb.any || nxt.p2 >= st_vb.hi1) &&
                                    (!st_ob.any || nxt.h2 >= st_ob.hi1 || !st_vb.any) &&
                                    (!st_va.any || nxt.p1 >= st_va.hi1 ||
                                     !st_ob.any || !st_vb.any) &&
                                    (!st_oa.any || nxt.h1 >= st_oa.hi1 ||
                                     !st_va.any || !st_ob.any || !st_vb.any);
            default:      in_last = 1'b0;
        endcase
    end

    always_comb
    begin
        later = 1'b0;
        for (int s = 0; s < N_SECTIONS; s++)
        begin
            if ((KIND_W'(s) > KIND_W'(nxt.sec)) && sec_exists[s])
            begin
                later = 1'b1;
            end
        end
    end

    always_comb
    begin
        res.alpha     = info.raw_alpha;
        res.beta      = info.raw_beta;
        res.kind      = KIND_W'(nxt.sec);
        res.last      = in_last && !later;
        res.exhausted = 1'b0;
        unique case (nxt.sec)
            SEC_A_SINGLE:
                res.alpha = info.raw_alpha ^ (one_hot(nxt.h1) | one_hot(nxt.p1));
            SEC_A_DOUBLE:
                res.alpha = info.raw_alpha ^ (one_hot(nxt.h1) | one_hot(nxt.h2) |
                                              one_hot(nxt.p1) | one_hot(nxt.p2));
            SEC_B_SINGLE:
                res.beta = info.raw_beta ^ (one_hot(nxt.h1) | one_hot(nxt.p1));
            SEC_B_DOUBLE:
                res.beta = info.raw_beta ^ (one_hot(nxt.h1) | one_hot(nxt.h2) |
                                            one_hot(nxt.p1) | one_hot(nxt.p2));
            SEC_MIXED:
            begin
                res.alpha = info.raw_alpha ^ (one_hot(nxt.h1) | one_hot(nxt.p1));
                res.beta  = info.raw_beta ^ (one_hot(nxt.h2) | one_hot(nxt.p2));
            end
            default: ;
        endcase
        if (!found)
        begin
            res.alpha     = '0;
            res.beta      = '0;
            res.kind      = '0;
            res.last      = 1'b0;
            res.exhausted = 1'b1;
        end
    end

endmodule

@@ hw/rtl/excitation_enumerator.sv @@
`timescale 1ns / 1ps

// Walks every single and double excitation of a reference determinant, one per
// request: alpha singles, alpha doubles, beta singles, beta doubles, then mixed
// alpha-beta doubles, indices ascending within each section. Program the alpha
// mask at 0x00, the beta mask at 0x08 and the orbital count at 0x10, then send a
// request with restart set for the first excitation and clear for each one after.
// The final excitation carries last_flag; later requests report exhausted until
// the next restart. Requests are taken one per clock cycle while out_ready keeps
// the result register draining; a request waits in the input register until the
// result register is free or draining, and its result is then loaded into it.
// The rate is set by the cursor register, whose successor is found combinationally
// by priority encoders over the 64-bit occupation masks.
module excitation_enumerator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [exen_pkg::ADDR_W-1:0]      paddr,
    input  logic [exen_pkg::DATA_W-1:0]      pwdata,
    output logic [exen_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             restart,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [exen_pkg::MASK_W-1:0]      excited_alpha,
    output logic [exen_pkg::MASK_W-1:0]      excited_beta,
    output logic [exen_pkg::KIND_W-1:0]      excitation_kind,
    output logic                             last_flag,
    output logic                             exhausted
);
    import exen_pkg::*;

    logic [MASK_W-1:0]  alpha_occupation;
    logic [MASK_W-1:0]  beta_occupation;
    logic [COUNT_W-1:0] orbital_count;
    scan_info_t         info;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    s1_restart_reg;
    logic    s1_restart_next;
    cursor_t cur_reg;
    cursor_t cur_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;
    result_t out_res_next;

    logic    in_fire;
    logic    s1_fire;
    cursor_t step_cur;
    result_t step_res;

    exen_apb_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .alpha_occupation (alpha_occupation),
        .beta_occupation  (beta_occupation),
        .orbital_count    (orbital_count)
    );

    exen_mask_scan u_scan (
        .alpha_occupation (alpha_occupation),
        .beta_occupation  (beta_occupation),
        .orbital_count    (orbital_count),
        .info             (info)
    );

    exen_step u_step (
        .restart (s1_restart_reg),
        .cur     (cur_reg),
        .info    (info),
        .nxt     (step_cur),
        .res     (step_res)
    );

    // Advance the held request whenever the result register is free or draining
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        s1_restart_next = s1_restart_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
            cur_next      = step_cur;
            out_res_next  = step_res;
        end
        if (in_fire)
        begin
            s1_valid_next   = 1'b1;
            s1_restart_next = restart;
        end
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg.sec   <= SEC_DONE;
            cur_reg.h1    <= '0;
            cur_reg.h2    <= '0;
            cur_reg.p1    <= '0;
            cur_reg.p2    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_restart_reg <= s1_restart_next;
        out_res_reg    <= out_res_next;
    end

    assign out_valid       = out_valid_reg;
    assign excited_alpha   = out_res_reg.alpha;
    assign excited_beta    = out_res_reg.beta;
    assign excitation_kind = out_res_reg.kind;
    assign last_flag       = out_res_reg.last;
    assign exhausted       = out_res_reg.exhausted;

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked result");

    a_done_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !s1_restart_reg && cur_reg.sec == SEC_DONE)
        |=> (out_valid_reg && out_res_reg.exhausted))
        else $error("advance past the end did not report exhausted");

    a_exhausted_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.exhausted) |-> (cur_reg.sec == SEC_DONE))
        else $error("exhausted result with a live cursor");

    a_last_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.last)
        |-> (!out_res_reg.exhausted && out_res_reg.kind <= KIND_W'(SEC_MIXED)))
        else $error("last flag on an invalid result");
`endif

endmodule
